@@ hdl/wnf_pkg.sv @@
// ----------------------------------------------------------------------------
// wnf_pkg: shared types and constants of the wildcard name filter
// Word formats, character codes, verdict codes and walker status.
// ----------------------------------------------------------------------------
package wnf_pkg;

    // input word: one pattern or name character
    typedef struct packed {
        logic       req_type;
        logic [7:0] char_value;
        logic       start_new;
    } req_word_t;

    // result word: one verdict per separator
    typedef struct packed {
        logic [1:0] verdict;
        logic       overflow;
    } res_word_t;

    // walker status toward the top level
    typedef struct packed {
        logic       busy;
        logic       done;
        logic [1:0] verdict;
    } walk_status_t;

    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_NAME    = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    localparam logic [1:0] V_MATCH = 2'd0;
    localparam logic [1:0] V_EXCL  = 2'd1;
    localparam logic [1:0] V_MISS  = 2'd2;

    // a literal pattern character (not a wildcard, not end of pattern)
    function automatic logic is_plain(input logic [7:0] c);
        return (c != CH_STAR) && (c != CH_QMARK) && (c != CH_NUL);
    endfunction

endpackage

@@ hdl/wildcard_name_filter.sv @@
// ----------------------------------------------------------------------------
// wildcard_name_filter: glob-style name filter
// Loads a pattern, streams names, and returns one verdict per separator.
// ----------------------------------------------------------------------------
// A pattern or name character is taken whenever no walk is in progress, and
// the next word can follow right behind it. A name word equal to the
// separator starts the match walk; the block stalls its input until the
// verdict has been handed to the output register. Each store access is a
// read state and then a compare state (one registered read port on each of
// the pattern and name stores), so the walk length is data dependent: it
// grows with the pattern characters and the name positions tried by the
// star search, bounded by 4*(PATTERN_DEPTH+4)*(NAME_DEPTH+4) pattern steps.
// A leading '!' negates the pattern; '*' and '?' are wildcards. Characters
// that do not fit in a store are dropped and flagged in the overflow bit of
// the next verdict. Stores need no clearing after reset.
module wildcard_name_filter #(
    parameter int PATTERN_DEPTH = 64,
    parameter int NAME_DEPTH    = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  wnf_pkg::req_word_t    req_word,
    output logic                  res_valid,
    input  logic                  res_stall,
    output wnf_pkg::res_word_t    res_word,
    input  logic                  cfg_wr_en,
    input  logic [7:0]            cfg_wr_data
);
    localparam int PW  = $clog2(PATTERN_DEPTH + 1);
    localparam int NLW = $clog2(NAME_DEPTH + 1);
    localparam int FW  = $clog2(NAME_DEPTH + PATTERN_DEPTH + 8) + 1;
    localparam int PIW = $clog2(PATTERN_DEPTH);
    localparam int NIW = $clog2(NAME_DEPTH);

    // fill state and separator
    logic [PW-1:0]  plen_reg;
    logic [NLW-1:0] nlen_reg;
    logic           ovf_reg;
    logic [7:0]     sep_reg;

    // output register
    logic               res_valid_reg;
    wnf_pkg::res_word_t res_word_reg;

    wnf_pkg::walk_status_t status;
    logic                  accept;
    logic                  is_pat;
    logic                  is_sep;
    logic [PW-1:0]         pat_base;
    logic                  pat_fits;
    logic                  name_fits;
    logic                  pat_wr;
    logic                  name_wr;
    logic                  start;
    logic                  take;
    logic                  handoff;
    logic [PW-1:0]         p_addr;
    logic [FW-1:0]         n_addr;
    logic [7:0]            p_data;
    logic [7:0]            n_data;

    assign req_stall = status.busy;
    assign accept    = req_valid && !req_stall;
    assign is_pat    = req_word.req_type == wnf_pkg::REQ_PATTERN;
    assign is_sep    = req_word.char_value == sep_reg;

    // start_new restarts the pattern at slot zero
    assign pat_base  = req_word.start_new ? '0 : plen_reg;
    assign pat_fits  = pat_base < PW'(PATTERN_DEPTH);
    assign name_fits = nlen_reg < NLW'(NAME_DEPTH);

    assign pat_wr  = accept && is_pat && pat_fits;
    assign name_wr = accept && !is_pat && !is_sep && name_fits;
    assign start   = accept && !is_pat && is_sep;

    // output slot is free when empty or being drained this cycle
    assign take    = !res_valid_reg || !res_stall;
    assign handoff = status.done && take;

    wnf_store #(
        .DEPTH (PATTERN_DEPTH),
        .AW    (PW),
        .LW    (PW)
    ) u_pat_store (
        .clk     (clk),
        .wr_en   (pat_wr),
        .wr_addr (pat_base[PIW-1:0]),
        .wr_data (req_word.char_value),
        .rd_addr (p_addr),
        .rd_len  (plen_reg),
        .at_len  (wnf_pkg::CH_NUL),
        .rd_data (p_data)
    );

    wnf_store #(
        .DEPTH (NAME_DEPTH),
        .AW    (FW),
        .LW    (NLW)
    ) u_name_store (
        .clk     (clk),
        .wr_en   (name_wr),
        .wr_addr (nlen_reg[NIW-1:0]),
        .wr_data (req_word.char_value),
        .rd_addr (n_addr),
        .rd_len  (nlen_reg),
        .at_len  (sep_reg),
        .rd_data (n_data)
    );

    wnf_walker #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .NAME_DEPTH    (NAME_DEPTH)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .take     (take),
        .sep_code (sep_reg),
        .name_len (nlen_reg),
        .p_data   (p_data),
        .n_data   (n_data),
        .p_addr   (p_addr),
        .n_addr   (n_addr),
        .status   (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            nlen_reg      <= '0;
            ovf_reg       <= 1'b0;
            sep_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_word_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sep_reg <= cfg_wr_data;
            end

            if (accept && is_pat)
            begin
                if (pat_fits)
                begin
                    plen_reg <= pat_base + PW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            else if (accept && !is_sep)
            begin
                if (name_fits)
                begin
                    nlen_reg <= nlen_reg + NLW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end

            // verdict goes out; name and overflow flag start over
            if (handoff)
            begin
                res_valid_reg         <= 1'b1;
                res_word_reg.verdict  <= status.verdict;
                res_word_reg.overflow <= ovf_reg;
                nlen_reg              <= '0;
                ovf_reg               <= 1'b0;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    // name store restarts after every verdict
    a_name_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        handoff |=> nlen_reg == '0)
        else $error("name length not cleared after verdict");

    // a verdict code is never 3
    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_word_reg.verdict != 2'd3)
        else $error("illegal verdict code");

    // fill counts stay within their stores
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= PW'(PATTERN_DEPTH) && nlen_reg <= NLW'(NAME_DEPTH))
        else $error("store fill count past depth");

    // no character is written while a walk is in progress
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !pat_wr && !name_wr)
        else $error("store written during walk");

endmodule

@@ hdl/wnf_store.sv @@
// ----------------------------------------------------------------------------
// wnf_store: character store with one write and one registered read port
// Reads at or past the fill length return the end value or zero.
// ----------------------------------------------------------------------------
module wnf_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 7,
    parameter int LW    = 7
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic [AW-1:0]            rd_addr,
    input  logic [LW-1:0]            rd_len,
    input  logic [7:0]               at_len,
    output logic [7:0]               rd_data
);
    localparam int IW = $clog2(DEPTH);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] word_reg;
    logic [7:0] at_len_reg;
    logic       below_reg;
    logic       at_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        word_reg   <= mem_reg[rd_addr[IW-1:0]];
        below_reg  <= rd_addr < AW'(rd_len);
        at_reg     <= rd_addr == AW'(rd_len);
        at_len_reg <= at_len;
    end

    assign rd_data = below_reg ? word_reg : (at_reg ? at_len_reg : 8'h00);

endmodule

@@ hdl/wnf_walker.sv @@
// ----------------------------------------------------------------------------
// wnf_walker: match sequencer
// Walks pattern against name with one backtrack point, one read per store
// per step through the shared compare path.
// ----------------------------------------------------------------------------
module wnf_walker #(
    parameter int PATTERN_DEPTH = 64,
    parameter int NAME_DEPTH    = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  take,
    input  logic [7:0]                            sep_code,
    input  logic [$clog2(NAME_DEPTH+1)-1:0]       name_len,
    input  logic [7:0]                            p_data,
    input  logic [7:0]                            n_data,
    output logic [$clog2(PATTERN_DEPTH+1)-1:0]    p_addr,
    output logic [$clog2(NAME_DEPTH+PATTERN_DEPTH+8):0] n_addr,
    output wnf_pkg::walk_status_t                 status
);
    localparam int PW = $clog2(PATTERN_DEPTH + 1);
    localparam int FW = $clog2(NAME_DEPTH + PATTERN_DEPTH + 8) + 1;
    localparam int unsigned WALK_LIMIT = 4 * (PATTERN_DEPTH + 4) * (NAME_DEPTH + 4);
    localparam int SW = $clog2(WALK_LIMIT + 1);

    typedef enum logic [21:0] {
        ST_IDLE     = 22'd1,
        ST_START    = 22'd2,
        ST_NEG      = 22'd4,
        ST_LOOP_RD  = 22'd8,
        ST_TOP      = 22'd16,
        ST_LSCAN_RD = 22'd32,
        ST_LSCAN    = 22'd64,
        ST_LEND_RD  = 22'd128,
        ST_LEND     = 22'd256,
        ST_Q_RD     = 22'd512,
        ST_Q        = 22'd1024,
        ST_Q2_RD    = 22'd2048,
        ST_Q2       = 22'd4096,
        ST_SSCAN_RD = 22'd8192,
        ST_SSCAN    = 22'd16384,
        ST_SSKIP_RD = 22'd32768,
        ST_SSKIP    = 22'd65536,
        ST_SEEK_RD  = 22'd131072,
        ST_SEEK     = 22'd262144,
        ST_SDONE_RD = 22'd524288,
        ST_SDONE    = 22'd1048576,
        ST_DONE     = 22'd2097152
    } state_t;

    state_t        state_reg, state_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic [PW-1:0] tmp_reg, tmp_next;
    logic [PW-1:0] gp_reg, gp_next;
    logic [PW-1:0] save_reg, save_next;
    logic [PW-1:0] len_reg, len_next;
    logic [PW-1:0] hit_reg, hit_next;
    logic [FW-1:0] f_reg, f_next;
    logic [FW-1:0] gf_reg, gf_next;
    logic [FW-1:0] pos_reg, pos_next;
    logic          gv_reg, gv_next;
    logic          neg_reg, neg_next;
    logic [7:0]    endc_reg, endc_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic [1:0]    verdict_reg, verdict_next;

    logic [1:0]    hitv;
    logic [1:0]    missv;
    logic [FW-1:0] nlen_ext;

    assign hitv     = neg_reg ? wnf_pkg::V_EXCL : wnf_pkg::V_MATCH;
    assign missv    = neg_reg ? wnf_pkg::V_MATCH : wnf_pkg::V_MISS;
    assign nlen_ext = FW'(name_len);

    // read addresses for the following state
    always_comb
    begin
        p_addr = '0;
        n_addr = '0;
        unique case (state_reg)
            ST_LOOP_RD, ST_SSCAN_RD, ST_SSKIP_RD: p_addr = ptr_reg;
            ST_LSCAN_RD:
            begin
                p_addr = ptr_reg;
                n_addr = f_reg + FW'(len_reg);
            end
            ST_Q2_RD:
            begin
                p_addr = ptr_reg;
                n_addr = f_reg;
            end
            ST_LEND_RD, ST_Q_RD, ST_SDONE_RD: n_addr = f_reg;
            ST_SEEK_RD:
            begin
                p_addr = tmp_reg + hit_reg + PW'(1);
                n_addr = pos_reg;
            end
            default:
            begin
                p_addr = '0;
                n_addr = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        tmp_next     = tmp_reg;
        gp_next      = gp_reg;
        save_next    = save_reg;
        len_next     = len_reg;
        hit_next     = hit_reg;
        f_next       = f_reg;
        gf_next      = gf_reg;
        pos_next     = pos_reg;
        gv_next      = gv_reg;
        neg_next     = neg_reg;
        endc_next    = endc_reg;
        steps_next   = steps_reg;
        verdict_next = verdict_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_START;
                end
            end
            ST_START: state_next = ST_NEG;
            ST_NEG:
            begin
                neg_next   = p_data == wnf_pkg::CH_BANG;
                ptr_next   = (p_data == wnf_pkg::CH_BANG) ? PW'(1) : '0;
                f_next     = '0;
                gf_next    = '0;
                gp_next    = '0;
                gv_next    = 1'b0;
                steps_next = '0;
                state_next = ST_LOOP_RD;
            end
            ST_LOOP_RD: state_next = ST_TOP;
            ST_TOP:
            begin
                if (p_data == wnf_pkg::CH_NUL || steps_reg >= SW'(WALK_LIMIT))
                begin
                    verdict_next = missv;
                    state_next   = ST_DONE;
                end
                else
                begin
                    steps_next = steps_reg + SW'(1);
                    tmp_next   = ptr_reg;
                    len_next   = '0;
                    if (p_data == wnf_pkg::CH_STAR)
                    begin
                        ptr_next   = ptr_reg + PW'(1);
                        state_next = ST_SSCAN_RD;
                    end
                    else if (p_data == wnf_pkg::CH_QMARK)
                    begin
                        state_next = ST_Q_RD;
                    end
                    else
                    begin
                        state_next = ST_LSCAN_RD;
                    end
                end
            end
            // literal run: scan and compare together
            ST_LSCAN_RD: state_next = ST_LSCAN;
            ST_LSCAN:
            begin
                if (wnf_pkg::is_plain(p_data))
                begin
                    if (n_data != p_data)
                    begin
                        if (gv_reg)
                        begin
                            f_next     = gf_reg;
                            ptr_next   = gp_reg;
                            state_next = ST_LOOP_RD;
                        end
                        else
                        begin
                            verdict_next = missv;
                            state_next   = ST_DONE;
                        end
                    end
                    else
                    begin
                        len_next   = len_reg + PW'(1);
                        ptr_next   = ptr_reg + PW'(1);
                        state_next = ST_LSCAN_RD;
                    end
                end
                else
                begin
                    endc_next  = p_data;
                    f_next     = f_reg + FW'(len_reg);
                    state_next = ST_LEND_RD;
                end
            end
            ST_LEND_RD: state_next = ST_LEND;
            ST_LEND:
            begin
                if (endc_reg == wnf_pkg::CH_NUL
                    && (n_data == wnf_pkg::CH_SPACE || n_data == sep_code))
                begin
                    verdict_next = hitv;
                    state_next   = ST_DONE;
                end
                else
                begin
                    state_next = ST_LOOP_RD;
                end
            end
            // single wildcard
            ST_Q_RD: state_next = ST_Q;
            ST_Q:
            begin
                if (f_reg >= nlen_ext || n_data == sep_code)
                begin
                    verdict_next = missv;
                    state_next   = ST_DONE;
                end
                else
                begin
                    f_next     = f_reg + FW'(1);
                    ptr_next   = ptr_reg + PW'(1);
                    state_next = ST_Q2_RD;
                end
            end
            ST_Q2_RD: state_next = ST_Q2;
            ST_Q2:
            begin
                state_next = ST_LOOP_RD;
                if (p_data == wnf_pkg::CH_NUL)
                begin
                    if (n_data == sep_code)
                    begin
                        verdict_next = hitv;
                        state_next   = ST_DONE;
                    end
                    else if (gv_reg)
                    begin
                        f_next   = gf_reg;
                        ptr_next = gp_reg;
                    end
                end
            end
            // star: measure the literal run after it
            ST_SSCAN_RD: state_next = ST_SSCAN;
            ST_SSCAN:
            begin
                if (wnf_pkg::is_plain(p_data))
                begin
                    len_next   = len_reg + PW'(1);
                    ptr_next   = ptr_reg + PW'(1);
                    state_next = ST_SSCAN_RD;
                end
                else
                begin
                    endc_next = p_data;
                    if (len_reg == '0)
                    begin
                        if (p_data == wnf_pkg::CH_STAR)
                        begin
                            save_next  = ptr_reg;
                            ptr_next   = ptr_reg + PW'(1);
                            state_next = ST_SSKIP_RD;
                        end
                        else if (p_data == wnf_pkg::CH_QMARK)
                        begin
                            gf_next    = f_reg + FW'(1);
                            gp_next    = tmp_reg;
                            gv_next    = 1'b1;
                            state_next = ST_LOOP_RD;
                        end
                        else
                        begin
                            verdict_next = hitv;
                            state_next   = ST_DONE;
                        end
                    end
                    else
                    begin
                        pos_next   = f_reg;
                        hit_next   = '0;
                        state_next = ST_SEEK_RD;
                    end
                end
            end
            // run of stars: trailing stars match everything
            ST_SSKIP_RD: state_next = ST_SSKIP;
            ST_SSKIP:
            begin
                if (p_data == wnf_pkg::CH_STAR)
                begin
                    ptr_next   = ptr_reg + PW'(1);
                    state_next = ST_SSKIP_RD;
                end
                else if (p_data == wnf_pkg::CH_NUL)
                begin
                    verdict_next = hitv;
                    state_next   = ST_DONE;
                end
                else
                begin
                    ptr_next   = save_reg;
                    gf_next    = f_reg + FW'(1);
                    gp_next    = tmp_reg;
                    gv_next    = 1'b1;
                    state_next = ST_LOOP_RD;
                end
            end
            // restart substring search
            ST_SEEK_RD:
            begin
                if (pos_reg >= nlen_ext)
                begin
                    verdict_next = missv;
                    state_next   = ST_DONE;
                end
                else
                begin
                    state_next = ST_SEEK;
                end
            end
            ST_SEEK:
            begin
                if (n_data == p_data)
                begin
                    pos_next = pos_reg + FW'(1);
                    hit_next = hit_reg + PW'(1);
                    if (hit_reg + PW'(1) == len_reg)
                    begin
                        f_next     = pos_reg + FW'(1);
                        state_next = ST_SDONE_RD;
                    end
                    else
                    begin
                        state_next = ST_SEEK_RD;
                    end
                end
                else
                begin
                    pos_next   = pos_reg + FW'(1) - FW'(hit_reg);
                    hit_next   = '0;
                    state_next = ST_SEEK_RD;
                end
            end
            ST_SDONE_RD: state_next = ST_SDONE;
            ST_SDONE:
            begin
                state_next = ST_LOOP_RD;
                if (endc_reg == wnf_pkg::CH_QMARK)
                begin
                    gf_next = (len_reg > PW'(1)) ? f_reg - FW'(len_reg) + FW'(1)
                                                 : f_reg + FW'(1);
                    gp_next = tmp_reg;
                    gv_next = 1'b1;
                end
                if (endc_reg == wnf_pkg::CH_NUL)
                begin
                    if (n_data == sep_code)
                    begin
                        verdict_next = hitv;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        ptr_next = tmp_reg;
                    end
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ptr_reg     <= '0;
            tmp_reg     <= '0;
            gp_reg      <= '0;
            save_reg    <= '0;
            len_reg     <= '0;
            hit_reg     <= '0;
            f_reg       <= '0;
            gf_reg      <= '0;
            pos_reg     <= '0;
            gv_reg      <= 1'b0;
            neg_reg     <= 1'b0;
            endc_reg    <= '0;
            steps_reg   <= '0;
            verdict_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            tmp_reg     <= tmp_next;
            gp_reg      <= gp_next;
            save_reg    <= save_next;
            len_reg     <= len_next;
            hit_reg     <= hit_next;
            f_reg       <= f_next;
            gf_reg      <= gf_next;
            pos_reg     <= pos_next;
            gv_reg      <= gv_next;
            neg_reg     <= neg_next;
            endc_reg    <= endc_next;
            steps_reg   <= steps_next;
            verdict_reg <= verdict_next;
        end
    end

    assign status.busy    = state_reg != ST_IDLE;
    assign status.done    = state_reg == ST_DONE;
    assign status.verdict = verdict_reg;

endmodule
